/* hdl/ppu_pkg.sv */
// ppu_pkg: shared types, constants and helpers for the particle pool block
// no dependencies; imported by every module of the block but ppu_ram
`default_nettype none

package ppu_pkg;

  // pool geometry
  localparam int MAX_SLOTS = 256;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int POOL_W    = 9;
  localparam int LIVE_W    = 9;
  localparam int LIVE_MAX  = 511;
  localparam int DT_W      = 16;

  localparam logic [POOL_W-1:0] POOL_RESET = 9'd256;

  // operation codes
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [DT_W-1:0]    time_step;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] speed_x;
    logic signed [31:0] speed_y;
    logic signed [31:0] life_time;
  } item_t;

  typedef struct packed {
    logic              added;
    logic [7:0]        slot_used;
    logic [LIVE_W-1:0] live_count;
  } result_t;

  // one slot as held in the state memory
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] life;
  } slot_t;

  localparam int SLOT_BITS = $bits(slot_t);

  // slot entering the integrator, aligned with the memory read data
  typedef struct packed {
    logic              valid;
    logic              active;
    logic [SLOT_W-1:0] idx;
  } step_t;

  // updated slot leaving the integrator
  typedef struct packed {
    logic              valid;
    logic              active;
    logic              alive;
    logic [SLOT_W-1:0] idx;
    slot_t             word;
  } wb_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_TICK,
    ST_DRAIN,
    ST_PRUNE,
    ST_DONE
  } state_t;

  // pool size clamped to the number of physical slots
  function automatic logic [CNT_W-1:0] eff_size(input logic [POOL_W-1:0] p);
    logic [31:0] wide;
    wide = 32'(p);
    if (wide > 32'(MAX_SLOTS)) begin
      return CNT_W'(MAX_SLOTS);
    end
    return CNT_W'(p);
  endfunction

  // active count as reported, saturated to the field width
  function automatic logic [LIVE_W-1:0] live_sat(input logic [CNT_W-1:0] n);
    if (32'(n) > 32'(LIVE_MAX)) begin
      return LIVE_W'(LIVE_MAX);
    end
    return LIVE_W'(n);
  endfunction

endpackage

`default_nettype wire

/* hdl/ppu_ram.sv */
// ppu_ram: generic single-write, single-read synchronous ram
// registered read data; no package dependency
`default_nettype none

module ppu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hdl/ppu_integrator.sv */
// ppu_integrator: two-stage euler update of one slot per cycle
// multiply stage, then add stage feeding write-back; uses ppu_pkg
`default_nettype none

module ppu_integrator
  import ppu_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire step_t           s1,
  input  wire slot_t           rdata,
  input  wire logic [DT_W-1:0] dt,
  output wb_t                  wb
);

  logic signed [48:0] prod_x;
  logic signed [48:0] prod_y;
  logic signed [31:0] life_new;

  logic               s2_valid;
  logic               s2_active;
  logic [SLOT_W-1:0]  s2_idx;
  logic signed [31:0] s2_life;
  logic signed [31:0] s2_step_x;
  logic signed [31:0] s2_step_y;
  slot_t              s2_word;

  // velocity times dt, dt as a non-negative operand
  always_comb begin
    prod_x   = rdata.vel_x * $signed({1'b0, dt});
    prod_y   = rdata.vel_y * $signed({1'b0, dt});
    life_new = rdata.life - $signed({16'b0, dt});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1.valid;
    end
    s2_active <= s1.active;
    s2_idx    <= s1.idx;
    s2_life   <= life_new;
    s2_step_x <= prod_x[47:16];
    s2_step_y <= prod_y[47:16];
    s2_word   <= rdata;
  end

  always_comb begin
    wb.valid      = s2_valid;
    wb.active     = s2_active;
    wb.idx        = s2_idx;
    wb.alive      = (s2_life > 32'sd0);
    wb.word       = s2_word;
    wb.word.life  = s2_life;
    wb.word.pos_x = s2_word.pos_x + s2_step_x;
    wb.word.pos_y = s2_word.pos_y + s2_step_y;
  end

endmodule

`default_nettype wire

/* hdl/ppu_ctrl.sv */
// ppu_ctrl: sequencer for add scan, tick sweep and resize pruning
// holds active flags, live count and pool size; uses ppu_pkg
`default_nettype none

module ppu_ctrl
  import ppu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire item_t             item_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [POOL_W-1:0] cfg_data,
  input  wire logic              res_free,
  output logic                   res_load,
  output result_t                res,
  output logic                   ram_we,
  output logic [SLOT_W-1:0]      ram_waddr,
  output slot_t                  ram_wdata,
  output logic                   ram_re,
  output logic [SLOT_W-1:0]      ram_raddr,
  output step_t                  s1,
  output logic [DT_W-1:0]        dt,
  input  wire wb_t               wb
);

  state_t            state, state_next;
  logic [POOL_W-1:0] pool_size, pool_size_next;
  logic [MAX_SLOTS-1:0] flags, flags_next;
  logic [CNT_W-1:0]  live, live_next;
  logic [CNT_W-1:0]  idx, idx_next;
  item_t             item, item_next;
  logic              s1_valid, s1_valid_next;
  logic [SLOT_W-1:0] s1_idx, s1_idx_next;
  logic              res_added, res_added_next;
  logic [SLOT_W-1:0] res_slot, res_slot_next;
  logic [CNT_W-1:0]  eff;
  logic [SLOT_W-1:0] idx_s;

  assign eff   = eff_size(pool_size);
  assign idx_s = idx[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pool_size <= POOL_RESET;
      flags     <= '0;
      live      <= '0;
      s1_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      pool_size <= pool_size_next;
      flags     <= flags_next;
      live      <= live_next;
      s1_valid  <= s1_valid_next;
    end
    idx       <= idx_next;
    item      <= item_next;
    s1_idx    <= s1_idx_next;
    res_added <= res_added_next;
    res_slot  <= res_slot_next;
  end

  always_comb begin
    state_next     = state;
    pool_size_next = pool_size;
    flags_next     = flags;
    live_next      = live;
    idx_next       = idx;
    item_next      = item;
    s1_valid_next  = 1'b0;
    s1_idx_next    = s1_idx;
    res_added_next = res_added;
    res_slot_next  = res_slot;
    item_ready     = 1'b0;
    cfg_ready      = 1'b0;
    res_load       = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = idx_s;
    ram_wdata      = '{pos_x: item.start_x, pos_y: item.start_y, vel_x: item.speed_x,
                       vel_y: item.speed_y, life: item.life_time};
    ram_re         = 1'b0;
    ram_raddr      = idx_s;

    // integrator write-back, only ever valid during a tick
    if (wb.valid && wb.active) begin
      ram_we             = 1'b1;
      ram_waddr          = wb.idx;
      ram_wdata          = wb.word;
      flags_next[wb.idx] = wb.alive;
      if (!wb.alive) begin
        live_next = live - CNT_W'(1);
      end
    end

    case (state)
      ST_IDLE: begin
        cfg_ready  = 1'b1;
        item_ready = !cfg_valid;
        idx_next   = '0;
        if (cfg_valid) begin
          pool_size_next = cfg_data;
          state_next     = ST_PRUNE;
        end else if (item_valid) begin
          item_next  = item_data;
          state_next = (item_data.opcode == OP_ADD) ? ST_ADD : ST_TICK;
        end
      end
      ST_ADD: begin
        if (idx >= eff) begin
          res_added_next = 1'b0;
          res_slot_next  = '0;
          state_next     = ST_DONE;
        end else if (!flags[idx_s]) begin
          ram_we            = 1'b1;
          flags_next[idx_s] = 1'b1;
          live_next         = live + CNT_W'(1);
          res_added_next    = 1'b1;
          res_slot_next     = idx_s;
          state_next        = ST_DONE;
        end else begin
          idx_next = idx + CNT_W'(1);
        end
      end
      ST_TICK: begin
        if (idx < eff) begin
          ram_re        = 1'b1;
          s1_valid_next = 1'b1;
          s1_idx_next   = idx_s;
          idx_next      = idx + CNT_W'(1);
        end else begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_valid && !wb.valid) begin
          res_added_next = 1'b0;
          res_slot_next  = '0;
          state_next     = ST_DONE;
        end
      end
      ST_PRUNE: begin
        if (idx == CNT_W'(MAX_SLOTS)) begin
          state_next = ST_IDLE;
        end else begin
          if (idx >= eff && flags[idx_s]) begin
            flags_next[idx_s] = 1'b0;
            live_next         = live - CNT_W'(1);
          end
          idx_next = idx + CNT_W'(1);
        end
      end
      ST_DONE: begin
        if (res_free) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res.added      = res_added;
    res.slot_used  = 8'(res_slot);
    res.live_count = live_sat(live);
    s1.valid       = s1_valid;
    s1.active      = flags[s1_idx];
    s1.idx         = s1_idx;
    dt             = item.time_step;
  end

endmodule

`default_nettype wire

/* hdl/particle_pool_update.sv */
// particle_pool_update: top level of the particle pool with euler integration
// instantiates ppu_ctrl, ppu_ram and ppu_integrator; uses ppu_pkg
//
// usage
//   item channel (item_valid/item_ready/item_data): one transaction is either an
//   add (opcode OP_ADD) that places a particle in the lowest free slot below the
//   pool size, or a tick (opcode OP_TICK) that ages and moves every live particle
//   by time_step. every item yields exactly one result transaction.
//   result channel (result_valid/result_ready/result_data): added flag, slot used
//   and the live count after the item.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): writes the pool size; slots at or
//   above the new size are dropped by a pruning sweep over all MAX_SLOTS slots
//   during which no item is taken.
// timing
//   items are handled one at a time, set by the single read/write port pair of
//   the slot memory. an add scans upward from slot 0 and shows its result once a
//   free slot is found or the pool size is reached; a tick reads each slot below
//   the pool size, clamped to MAX_SLOTS, one memory read per slot, through the
//   two-stage multiply/add pipeline and shows its result once the pipeline has
//   drained. the next item can be taken as soon as the result appears.
// reset
//   synchronous rst clears all active flags and the live count and sets the pool
//   size to 256; slot contents are not cleared, only data of live slots is used.
// stalls
//   the result sits in an output register; the next item is accepted while it
//   waits, but its own result is held back until the register is free.
`default_nettype none

module particle_pool_update
  import ppu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire item_t             item_data,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output result_t                result_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [POOL_W-1:0] cfg_data
);

  logic              res_free;
  logic              res_load;
  result_t           res;
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  slot_t             ram_wdata;
  logic              ram_re;
  logic [SLOT_W-1:0] ram_raddr;
  logic [SLOT_BITS-1:0] ram_rdata;
  step_t             s1;
  logic [DT_W-1:0]   dt;
  wb_t               wb;

  // output register is free when empty or being drained this cycle
  assign res_free = !result_valid || result_ready;

  ppu_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item_data  (item_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .res_free   (res_free),
    .res_load   (res_load),
    .res        (res),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .s1         (s1),
    .dt         (dt),
    .wb         (wb)
  );

  // all five per-slot fields share one wide entry
  ppu_ram #(
    .WIDTH (SLOT_BITS),
    .DEPTH (MAX_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ppu_integrator u_integ (
    .clk   (clk),
    .rst   (rst),
    .s1    (s1),
    .rdata (slot_t'(ram_rdata)),
    .dt    (dt),
    .wb    (wb)
  );

  // result output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (res_load) begin
      result_data <= res;
    end
  end

endmodule

`default_nettype wire

/* hdl/ppu_checker.sv */
// ppu_checker: port-level assertions for particle_pool_update
// bound to the top level below; uses ppu_pkg
`default_nettype none

module ppu_checker
  import ppu_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              item_valid,
  input wire logic              item_ready,
  input wire item_t             item_data,
  input wire logic              result_valid,
  input wire logic              result_ready,
  input wire result_t           result_data,
  input wire logic              cfg_valid,
  input wire logic              cfg_ready,
  input wire logic [POOL_W-1:0] cfg_data
);

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_data))
    else $error("result changed while stalled");

  // nothing is shown right after reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // an accepted item leaves neither channel ready in the cycle after
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready && !cfg_ready)
    else $error("second transaction taken while busy");

  // a failed add or a tick names no slot
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_data.added |-> result_data.slot_used == 8'd0)
    else $error("slot reported without an add");

  // live count never exceeds the number of physical slots
  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> 32'(result_data.live_count) <= 32'(MAX_SLOTS))
    else $error("live count above pool capacity");

endmodule

bind particle_pool_update ppu_checker u_ppu_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .item_data    (item_data),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result_data  (result_data),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready),
  .cfg_data     (cfg_data)
);

`default_nettype wire
